[hw/rtl/rdh_pkg.sv]
// ----------------------------------------------------------------------------
// rdh_pkg
// Shared types and constants for the reuse distance histogram.
// ----------------------------------------------------------------------------
package rdh_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int COUNT_BITS_DEF = 48;
  localparam int KEY_W          = 32;
  localparam int BIN_W          = 7;
  localparam int OUT_COUNT_W    = 48;

  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture input item
    logic search;  // register stack compare result
    logic update;  // on access shift stack, bump counter; latch result
  } rdh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
  } rdh_sts_t;

endpackage

[hw/rtl/reuse_distance_histogram.sv]
// The result follows the input transfer through the search and update states.
// The capture, stack search and stack shift/counter update steps run in
// sequence on one item; a new item is taken only once back in idle.
// Reset: synchronous active-low rst_n empties the stack and marks every
// counter as zero at once; the block takes items in the next cycle.
// ----------------------------------------------------------------------------
// reuse_distance_histogram
// LRU stack distance profiler with saturating per-distance counters.
// ----------------------------------------------------------------------------
module reuse_distance_histogram #(
  parameter int DEPTH      = rdh_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = rdh_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = rdh_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [rdh_pkg::KEY_W-1:0]       in_key,
  input  logic [rdh_pkg::BIN_W-1:0]       in_bin_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rdh_pkg::BIN_W-1:0]       out_distance,
  output logic                            out_is_far,
  output logic [rdh_pkg::OUT_COUNT_W-1:0] out_count
);
  import rdh_pkg::*;

  rdh_cmd_t cmd;
  rdh_sts_t sts;

  rdh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  rdh_dp #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_kind), .in_key(in_key), .in_bin_index(in_bin_index),
    .out_distance(out_distance), .out_is_far(out_is_far), .out_count(out_count)
  );

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.search, cmd.update}))
    else $error("overlapping datapath commands");

  a_search_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.search)
    else $error("search did not follow load");

  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid)
    else $error("result missing after update");
endmodule

[hw/rtl/rdh_ctrl.sv]
// ----------------------------------------------------------------------------
// rdh_ctrl
// Sequencer: capture, search, update, then hold the result for transfer.
// ----------------------------------------------------------------------------
module rdh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rdh_pkg::rdh_sts_t sts,
  output rdh_pkg::rdh_cmd_t cmd
);
  import rdh_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_UPDATE} state_t;

  state_t state_r;
  logic   out_valid_r;

  // accept in idle while the result slot is free or drains this cycle
  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.search = (state_r == S_SEARCH);
  assign cmd.update = (state_r == S_UPDATE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd.load) state_r <= S_SEARCH;
        end
        S_SEARCH: begin
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  wire unused_sts = sts.is_read;
endmodule

[hw/rtl/rdh_dp.sv]
// ----------------------------------------------------------------------------
// rdh_dp
// LRU stack with parallel compare, hit priority search, saturating counters.
// ----------------------------------------------------------------------------
module rdh_dp #(
  parameter int DEPTH      = rdh_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = rdh_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = rdh_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rdh_pkg::rdh_cmd_t                cmd,
  output rdh_pkg::rdh_sts_t                sts,
  input  logic                             in_kind,
  input  logic [rdh_pkg::KEY_W-1:0]        in_key,
  input  logic [rdh_pkg::BIN_W-1:0]        in_bin_index,
  output logic [rdh_pkg::BIN_W-1:0]        out_distance,
  output logic                             out_is_far,
  output logic [rdh_pkg::OUT_COUNT_W-1:0]  out_count
);
  import rdh_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int BW = (BIN_W > PW + 1) ? BIN_W : PW + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [BW-1:0] DEPTH_B = BW'(DEPTH);

  logic [KEY_BITS-1:0]   keys_r  [DEPTH];
  logic [DEPTH-1:0]      valid_r;
  logic [COUNT_BITS-1:0] hist_r  [DEPTH];
  logic [DEPTH-1:0]      hist_vld_r;
  logic [COUNT_BITS-1:0] far_r;

  logic                kind_r;
  logic [KEY_BITS-1:0] key_r;
  logic [BIN_W-1:0]    bin_r;
  logic                hit_r;
  logic [PW-1:0]       pos_r;
  logic [COUNT_BITS-1:0] sel_r;

  logic [BIN_W-1:0]       dist_r;
  logic                   far_flag_r;
  logic [OUT_COUNT_W-1:0] cnt_r;

  logic [KEY_BITS-1:0] key_in;
  logic [DEPTH-1:0]    match_c;
  logic [DEPTH-1:0]    first_c;
  logic [PW-1:0]       pos_c;
  logic [DEPTH-1:0]    shift_c;
  logic [COUNT_BITS-1:0] inc_c;
  logic [BW-1:0]       bin_w;
  logic [PW-1:0]       rd_addr_c;
  logic [COUNT_BITS-1:0] rd_data_c;

  assign key_in = KEY_BITS'({{(KEY_BITS > KEY_W ? KEY_BITS - KEY_W : 0){1'b0}}, in_key});
  assign sts.is_read = kind_r;
  assign bin_w = BW'(bin_r);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) match_c[i] = valid_r[i] && (keys_r[i] == key_r);
    first_c = match_c & (~match_c + DEPTH'(1));
    pos_c = '0;
    for (int i = 0; i < DEPTH; i++) if (first_c[i]) pos_c = pos_c | PW'(i);
  end

  assign rd_addr_c = (kind_r == KIND_ACCESS) ? pos_c : bin_r[PW-1:0];
  assign rd_data_c = hist_vld_r[rd_addr_c] ? hist_r[rd_addr_c] : '0;

  // entries at or above the hit move down; a miss moves all
  always_comb begin
    for (int i = 0; i < DEPTH; i++) shift_c[i] = !hit_r || (PW'(i) <= pos_r);
  end

  assign inc_c = (sel_r == CMAX) ? CMAX : sel_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      hist_vld_r <= '0;
      far_r      <= '0;
    end else if (cmd.update && kind_r == KIND_ACCESS) begin
      for (int i = DEPTH - 1; i > 0; i--) begin
        if (shift_c[i]) begin
          keys_r[i]  <= keys_r[i-1];
          valid_r[i] <= valid_r[i-1];
        end
      end
      keys_r[0]  <= key_r;
      valid_r[0] <= 1'b1;
      if (hit_r) begin
        hist_r[pos_r]     <= inc_c;
        hist_vld_r[pos_r] <= 1'b1;
      end else begin
        far_r <= inc_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      key_r  <= key_in;
      bin_r  <= in_bin_index;
    end
    if (cmd.search) begin
      hit_r <= |match_c;
      if (kind_r == KIND_ACCESS) begin
        pos_r <= pos_c;
        sel_r <= (|match_c) ? rd_data_c : far_r;
      end else begin
        pos_r <= bin_r[PW-1:0];
        sel_r <= (bin_w < DEPTH_B) ? rd_data_c :
                 (bin_w == DEPTH_B) ? far_r : '0;
      end
    end
    if (cmd.update) begin
      if (kind_r == KIND_ACCESS) begin
        dist_r     <= hit_r ? BIN_W'(pos_r) : BIN_W'(DEPTH);
        far_flag_r <= !hit_r;
        cnt_r      <= OUT_COUNT_W'(inc_c);
      end else begin
        dist_r     <= bin_r;
        far_flag_r <= (bin_w == DEPTH_B);
        cnt_r      <= OUT_COUNT_W'(sel_r);
      end
    end
  end

  assign out_distance = dist_r;
  assign out_is_far   = far_flag_r;
  assign out_count    = cnt_r;
endmodule

[dv/reuse_distance_histogram_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reuse_distance_histogram_tb
// Drives key accesses and bin reads into the LRU stack distance profiler,
// tracks its stack and counters in a scoreboard model and checks every
// result transfer against it, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module reuse_distance_histogram_tb;
  import rdh_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [BIN_W-1:0]       distance;
    logic                   is_far;
    logic [OUT_COUNT_W-1:0] count;
  } lookup_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_kind;
  logic [KEY_W-1:0]       in_key;
  logic [BIN_W-1:0]       in_bin_index;
  logic                   out_valid;
  logic                   out_ready;
  logic [BIN_W-1:0]       out_distance;
  logic                   out_is_far;
  logic [OUT_COUNT_W-1:0] out_count;

  logic [KEY_W-1:0]       lru_key [STACK_DEPTH];
  logic                   lru_vld [STACK_DEPTH];
  logic [OUT_COUNT_W-1:0] bin_count [STACK_DEPTH];
  logic [OUT_COUNT_W-1:0] far_total;
  lookup_result_t         pending_results[$];

  int unsigned in_transfers;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned mode_cycles;
  logic        failed;
  logic [KEY_W-1:0] key_pool [128];
  int unsigned pool_size;

  reuse_distance_histogram uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_key       (in_key),
    .in_bin_index (in_bin_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_distance (out_distance),
    .out_is_far   (out_is_far),
    .out_count    (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [OUT_COUNT_W-1:0] bump(logic [OUT_COUNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Advance the LRU stack model and compute the expected result.
  task automatic predict_distance(logic kind, logic [KEY_W-1:0] key,
                                  logic [BIN_W-1:0] bin);
    lookup_result_t r;
    int hit;
    int top;
    hit = STACK_DEPTH;
    if (kind == KIND_ACCESS) begin
      for (int p = STACK_DEPTH - 1; p >= 0; p--) begin
        if (lru_vld[p] && lru_key[p] == key) hit = p;
      end
      if (hit < STACK_DEPTH) begin
        bin_count[hit] = bump(bin_count[hit]);
        r = '{distance: BIN_W'(hit), is_far: 1'b0, count: bin_count[hit]};
        top = hit;
      end else begin
        far_total = bump(far_total);
        r = '{distance: BIN_W'(STACK_DEPTH), is_far: 1'b1, count: far_total};
        top = STACK_DEPTH - 1;
      end
      for (int i = top; i > 0; i--) begin
        lru_key[i] = lru_key[i-1];
        lru_vld[i] = lru_vld[i-1];
      end
      lru_key[0] = key;
      lru_vld[0] = 1'b1;
    end else if (bin < STACK_DEPTH) begin
      r = '{distance: bin, is_far: 1'b0, count: bin_count[bin]};
    end else if (bin == STACK_DEPTH) begin
      r = '{distance: bin, is_far: 1'b1, count: far_total};
    end else begin
      r = '{distance: bin, is_far: 1'b0, count: '0};
    end
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_distance(in_kind, in_key, in_bin_index);
      in_transfers <= in_transfers + 1;
    end
  end

  always @(posedge clk) begin
    lookup_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: distance=%0d is_far=%0d count=%0d",
                   out_distance, out_is_far, out_count);
      end else begin
        e = pending_results.pop_front();
        if (out_distance !== e.distance || out_is_far !== e.is_far ||
            out_count !== e.count) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp dist=%0d far=%0d count=%0d, got dist=%0d far=%0d count=%0d",
                     e.distance, e.is_far, e.count, out_distance, out_is_far, out_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("reuse_distance_histogram test failed");
      $finish;
    end
  end

  // Receiver: switch between full speed, light and heavy stalls.
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      mode_cycles <= $urandom_range(16, 120);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Send one item; return at the falling edge after its transfer.
  task automatic send_item(logic kind, logic [KEY_W-1:0] key, logic [BIN_W-1:0] bin);
    int unsigned target;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    target       = in_transfers + 1;
    in_valid     = 1'b1;
    in_kind      = kind;
    in_key       = key;
    in_bin_index = bin;
    do @(negedge clk); while (in_transfers < target);
  endtask

  task automatic access_key(logic [KEY_W-1:0] key);
    send_item(KIND_ACCESS, key, BIN_W'($urandom_range(0, 127)));
  endtask

  task automatic read_bin(logic [BIN_W-1:0] bin);
    send_item(KIND_READ, $urandom, bin);
  endtask

  task automatic test_directed_edges();
    access_key('0);
    access_key('0);
    access_key('1);
    access_key('0);
    access_key('1);
    access_key(32'h5555_AAAA);
    access_key(32'hAAAA_5555);
    access_key('1);
    read_bin(0);
    read_bin(1);
    read_bin(2);
    read_bin(STACK_DEPTH - 1);
    read_bin(STACK_DEPTH);
    read_bin(STACK_DEPTH + 1);
    read_bin('1);
  endtask

  // Fill the stack, reach the bottom entry, then push an entry off.
  task automatic test_deep_stack();
    for (int i = 0; i < STACK_DEPTH; i++) access_key(32'h1000_0000 + i);
    access_key(32'h1000_0000);
    access_key(32'h1000_0000 + STACK_DEPTH);
    access_key(32'h1000_0001);
    access_key(32'h1000_0000 + STACK_DEPTH - 1);
    read_bin(STACK_DEPTH - 1);
    read_bin(STACK_DEPTH);
  endtask

  task automatic test_random_trace(int unsigned n_items);
    int unsigned sel;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        pool_size = $urandom_range(0, 1) ? $urandom_range(2, 20) : $urandom_range(40, 100);
        for (int k = 0; k < 128; k++) key_pool[k] = $urandom;
      end
      sel = $urandom_range(0, 99);
      if (sel < 12)
        read_bin(sel < 3 ? BIN_W'($urandom_range(0, 127))
                         : BIN_W'($urandom_range(0, STACK_DEPTH)));
      else if (sel < 17)
        access_key($urandom);
      else
        access_key(key_pool[$urandom_range(0, pool_size - 1)]);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = KIND_ACCESS;
    in_key       = '0;
    in_bin_index = '0;
    out_ready    = 1'b0;
    failed       = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    in_transfers = 0;
    burst_left   = 0;
    stall_mode   = 0;
    mode_cycles  = 0;
    far_total    = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      lru_key[i]   = '0;
      lru_vld[i]   = 1'b0;
      bin_count[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_deep_stack();
    test_random_trace(1100);
    in_valid = 1'b0;

    while (pending_results.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (pending_results.size() > 0) failed = 1'b1;
    if (!failed) begin
      $display("reuse_distance_histogram test passed");
    end else begin
      $display("reuse_distance_histogram test failed");
    end
    $finish;
  end

endmodule
